// ----- rtl/dpp_pkg.sv -----
package dpp_pkg;

  // input field widths
  localparam int COORD_WIDTH = 12;
  localparam int DEPTH_WIDTH = 16;

  // fixed formats of the register fields
  localparam int CENTRE_W = 16;  // unsigned Q12.4
  localparam int RECIP_W  = 24;  // unsigned Q0.24
  localparam int COEF_W   = 20;  // signed Q2.17 or integer mm offset
  localparam int LIMIT_W  = 16;
  localparam int OUT_W    = 32;  // signed Q23.8

  localparam int RECIP_SHIFT = 20;  // Q.28 -> Q.8
  localparam int COEF_SHIFT  = 17;  // Q.25 -> Q.8
  localparam int OFFSET_SHIFT = 25;
  localparam int DEPTH_SHIFT  = 8;

  // datapath widths
  localparam int COLQ_W = COORD_WIDTH + 4;
  localparam int DX_W   = ((COLQ_W > CENTRE_W) ? COLQ_W : CENTRE_W) + 1;
  localparam int MD_W   = DX_W + DEPTH_WIDTH;
  localparam int P_W    = MD_W + RECIP_W;
  localparam int CV_W   = P_W - RECIP_SHIFT + 1;
  localparam int CZ_W   = DEPTH_WIDTH + DEPTH_SHIFT + 1;
  localparam int PR_W   = CV_W + COEF_W;
  localparam int ACC_W  = PR_W + 2;
  localparam int RND_W  = ACC_W + 1 - COEF_SHIFT;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CROP_WINDOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_FOCAL  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_LIMITS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CAM_X    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CAM_Y    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CAM_Z    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET   = 4'd7;

  localparam logic [63:0] CROP_RESET      = 64'h01A8_0000_0200_0000;
  localparam logic [31:0] PRINCIPAL_RESET = 32'h0D40_1000;
  localparam logic [47:0] RECIP_RESET     = 48'h00B38C_00B38C;
  localparam logic [31:0] BG_LIMITS_RESET = 32'h0064_01F4;
  localparam logic [59:0] ROW_X_RESET     = {20'h0, 20'h0, 20'h20000};
  localparam logic [59:0] ROW_Y_RESET     = {20'h0, 20'h20000, 20'h0};
  localparam logic [59:0] ROW_Z_RESET     = {20'h20000, 20'h0, 20'h0};
  localparam logic [59:0] ROW_OFS_RESET   = 60'h0;

  localparam int NUM_STAGES = 7;

endpackage

// ----- rtl/depth_pixel_to_point.sv -----
// channel   direction  handshake              beat contents
// in_       input      in_valid / in_stall    column, row, depth, background, frame_end
// out_      output     out_valid / out_stall  point_valid, point x/y/z (Q23.8 mm), frame_done
// cfg_      input      cfg_valid / cfg_ready  register index, 64-bit write data
//
// seven register stages, one pixel per cycle sustained while out_stall is low; the stages
// in order: tests, two back-projection multiplies, rounding, matrix multiply, adder,
// round/saturate
// rst_n is synchronous: it empties the pipeline and loads the calibration defaults
// each stage holds while the one after it is full and stalled, so bubbles collapse
// and pixels keep entering while a finished point waits at the output
module depth_pixel_to_point (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpp_pkg::COORD_WIDTH-1:0]     in_pixel_column,
  input  logic [dpp_pkg::COORD_WIDTH-1:0]     in_pixel_row,
  input  logic [dpp_pkg::DEPTH_WIDTH-1:0]     in_depth_sample,
  input  logic [dpp_pkg::DEPTH_WIDTH-1:0]     in_background_sample,
  input  logic                                in_frame_end,
  // point output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_point_valid,
  output logic signed [dpp_pkg::OUT_W-1:0]    out_point_x,
  output logic signed [dpp_pkg::OUT_W-1:0]    out_point_y,
  output logic signed [dpp_pkg::OUT_W-1:0]    out_point_z,
  output logic                                out_frame_done,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NS = dpp_pkg::NUM_STAGES;

  // ---------------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------------
  logic [63:0] crop_r;
  logic [31:0] principal_r;
  logic [47:0] recip_r;
  logic [31:0] bg_limits_r;
  logic [59:0] row_x_r, row_y_r, row_z_r, row_ofs_r;

  // the user must write only while the pipeline is drained; the block does not enforce it and always takes writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_r      <= dpp_pkg::CROP_RESET;
      principal_r <= dpp_pkg::PRINCIPAL_RESET;
      recip_r     <= dpp_pkg::RECIP_RESET;
      bg_limits_r <= dpp_pkg::BG_LIMITS_RESET;
      row_x_r     <= dpp_pkg::ROW_X_RESET;
      row_y_r     <= dpp_pkg::ROW_Y_RESET;
      row_z_r     <= dpp_pkg::ROW_Z_RESET;
      row_ofs_r   <= dpp_pkg::ROW_OFS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpp_pkg::REG_CROP_WINDOW: crop_r      <= cfg_data;
        dpp_pkg::REG_PRINCIPAL:   principal_r <= cfg_data[31:0];
        dpp_pkg::REG_RECIP_FOCAL: recip_r     <= cfg_data[47:0];
        dpp_pkg::REG_BG_LIMITS:   bg_limits_r <= cfg_data[31:0];
        dpp_pkg::REG_ROW_CAM_X:   row_x_r     <= cfg_data[59:0];
        dpp_pkg::REG_ROW_CAM_Y:   row_y_r     <= cfg_data[59:0];
        dpp_pkg::REG_ROW_CAM_Z:   row_z_r     <= cfg_data[59:0];
        dpp_pkg::REG_ROW_OFFSET:  row_ofs_r   <= cfg_data[59:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // register fields
  logic [15:0] x_start, x_end, y_start, y_end;
  logic [dpp_pkg::CENTRE_W-1:0] cx, cy;
  logic [dpp_pkg::RECIP_W-1:0]  rfx, rfy;
  logic [dpp_pkg::LIMIT_W-1:0]  margin, min_bg;

  assign x_start = crop_r[15:0];
  assign x_end   = crop_r[31:16];
  assign y_start = crop_r[47:32];
  assign y_end   = crop_r[63:48];
  assign cx      = principal_r[15:0];
  assign cy      = principal_r[31:16];
  assign rfx     = recip_r[23:0];
  assign rfy     = recip_r[47:24];
  assign margin  = bg_limits_r[15:0];
  assign min_bg  = bg_limits_r[31:16];

  // ---------------------------------------------------------------------------
  // pipeline flow control: stage k loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic [NS:1]   v_r;
  logic [NS+1:1] ready;

  always_comb begin
    ready[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      ready[k] = !v_r[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ready[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (ready[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // keep flag and frame marker ride along with every stage
  logic [NS:1] keep_r, frame_r;

  // ---------------------------------------------------------------------------
  // stage 1: window and foreground tests, offset from the principal point
  // ---------------------------------------------------------------------------
  localparam int DX_W = dpp_pkg::DX_W;

  logic                                 keep_s0;
  logic                                 bg_above;
  logic [dpp_pkg::DEPTH_WIDTH-1:0]      fg_gap;
  logic signed [dpp_pkg::DX_W-1:0]      dx_s0, dy_s0;

  assign bg_above = in_background_sample > in_depth_sample;
  assign fg_gap   = in_background_sample - in_depth_sample;

  assign keep_s0 = (16'(in_pixel_column) >= x_start) && (16'(in_pixel_column) < x_end) &&
                   (16'(in_pixel_row) >= y_start) && (16'(in_pixel_row) < y_end) &&
                   (in_depth_sample != '0) &&
                   bg_above && (16'(fg_gap) > margin) &&
                   (16'(in_background_sample) >= min_bg);

  // column in Q.4 minus cx, both zero-extended then subtracted as signed
  assign dx_s0 = $signed(DX_W'({in_pixel_column, 4'b0000})) - $signed(DX_W'(cx));
  assign dy_s0 = $signed(DX_W'({in_pixel_row, 4'b0000})) - $signed(DX_W'(cy));

  logic signed [dpp_pkg::DX_W-1:0]    s1_dx_r, s1_dy_r;
  logic [dpp_pkg::DEPTH_WIDTH-1:0]    s1_depth_r;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s1_dx_r    <= dx_s0;
      s1_dy_r    <= dy_s0;
      s1_depth_r <= in_depth_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      keep_r[1]  <= keep_s0;
      frame_r[1] <= in_frame_end;
    end
    for (int k = 2; k <= NS; k++) begin
      if (ready[k]) begin
        keep_r[k]  <= keep_r[k-1];
        frame_r[k] <= frame_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: offset times depth
  // ---------------------------------------------------------------------------
  localparam int MD_W = dpp_pkg::MD_W;

  logic signed [dpp_pkg::MD_W-1:0]    s2_mx_r, s2_my_r;
  logic [dpp_pkg::DEPTH_WIDTH-1:0]    s2_depth_r;

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      s2_mx_r    <= MD_W'(s1_dx_r * $signed({1'b0, s1_depth_r}));
      s2_my_r    <= MD_W'(s1_dy_r * $signed({1'b0, s1_depth_r}));
      s2_depth_r <= s1_depth_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: times reciprocal focal length (Q.28)
  // ---------------------------------------------------------------------------
  localparam int P_W = dpp_pkg::P_W;

  logic signed [dpp_pkg::P_W-1:0]     s3_px_r, s3_py_r;
  logic [dpp_pkg::DEPTH_WIDTH-1:0]    s3_depth_r;

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      s3_px_r    <= P_W'(s2_mx_r * $signed({1'b0, rfx}));
      s3_py_r    <= P_W'(s2_my_r * $signed({1'b0, rfy}));
      s3_depth_r <= s2_depth_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: round camera X/Y to Q.8, nearest with ties away from zero
  // (v + half - sign) >>> shift gives that in one add
  // ---------------------------------------------------------------------------
  localparam int CV_W = dpp_pkg::CV_W;
  localparam int CZ_W = dpp_pkg::CZ_W;
  localparam int RS   = dpp_pkg::RECIP_SHIFT;

  logic signed [P_W:0] rx_sum, ry_sum;

  assign rx_sum = $signed({s3_px_r[P_W-1], s3_px_r}) + $signed((P_W+1)'(1) << (RS-1))
                  - $signed((P_W+1)'(s3_px_r[P_W-1]));
  assign ry_sum = $signed({s3_py_r[P_W-1], s3_py_r}) + $signed((P_W+1)'(1) << (RS-1))
                  - $signed((P_W+1)'(s3_py_r[P_W-1]));

  logic signed [dpp_pkg::CV_W-1:0]    s4_cx_r, s4_cy_r;
  logic signed [dpp_pkg::CZ_W-1:0]    s4_cz_r;

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      s4_cx_r <= CV_W'(rx_sum >>> RS);
      s4_cy_r <= CV_W'(ry_sum >>> RS);
      s4_cz_r <= $signed({1'b0, s3_depth_r, dpp_pkg::DEPTH_SHIFT'(0)});
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: nine coefficient products, [j] is the output axis, [k] the camera axis
  // ---------------------------------------------------------------------------
  localparam int PR_W = dpp_pkg::PR_W;
  localparam int CW   = dpp_pkg::COEF_W;

  logic signed [dpp_pkg::PR_W-1:0] s5_prod_r [3][3];

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      for (int j = 0; j < 3; j++) begin
        s5_prod_r[j][0] <= PR_W'(s4_cx_r * $signed(row_x_r[CW*j +: CW]));
        s5_prod_r[j][1] <= PR_W'(s4_cy_r * $signed(row_y_r[CW*j +: CW]));
        s5_prod_r[j][2] <= PR_W'(s4_cz_r * $signed(row_z_r[CW*j +: CW]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: accumulate with the offset in Q.25
  // ---------------------------------------------------------------------------
  localparam int ACC_W = dpp_pkg::ACC_W;

  logic signed [dpp_pkg::ACC_W-1:0] s6_acc_r [3];

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      for (int j = 0; j < 3; j++) begin
        s6_acc_r[j] <= ACC_W'(s5_prod_r[j][0]) + ACC_W'(s5_prod_r[j][1]) +
                       ACC_W'(s5_prod_r[j][2]) +
                       (ACC_W'($signed(row_ofs_r[CW*j +: CW])) <<< dpp_pkg::OFFSET_SHIFT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7 (output register): round to Q.8, saturate to 32 bits, zero if rejected
  // ---------------------------------------------------------------------------
  localparam int RND_W = dpp_pkg::RND_W;
  localparam int CS    = dpp_pkg::COEF_SHIFT;
  localparam int OW    = dpp_pkg::OUT_W;

  logic signed [ACC_W:0]           acc_rnd [3];
  logic signed [RND_W-1:0]         acc_q8  [3];
  logic signed [OW-1:0]            pt_s6   [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_rnd[j] = $signed({s6_acc_r[j][ACC_W-1], s6_acc_r[j]})
                   + $signed((ACC_W+1)'(1) << (CS-1))
                   - $signed((ACC_W+1)'(s6_acc_r[j][ACC_W-1]));
      acc_q8[j]  = RND_W'(acc_rnd[j] >>> CS);
      // fits when every bit above the sign position matches the sign
      if (acc_q8[j][RND_W-1:OW-1] == '0 || acc_q8[j][RND_W-1:OW-1] == '1) begin
        pt_s6[j] = acc_q8[j][OW-1:0];
      end else if (acc_q8[j][RND_W-1]) begin
        pt_s6[j] = {1'b1, {(OW-1){1'b0}}};
      end else begin
        pt_s6[j] = {1'b0, {(OW-1){1'b1}}};
      end
      if (!keep_r[6]) pt_s6[j] = '0;
    end
  end

  logic signed [OW-1:0] s7_pt_r [3];

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      for (int j = 0; j < 3; j++) begin
        s7_pt_r[j] <= pt_s6[j];
      end
    end
  end

  assign out_valid       = v_r[NS];
  assign out_point_valid = keep_r[NS];
  assign out_frame_done  = frame_r[NS];
  assign out_point_x     = s7_pt_r[0];
  assign out_point_y     = s7_pt_r[1];
  assign out_point_z     = s7_pt_r[2];

endmodule

// ----- tb/sv/tb_depth_pixel_to_point.sv -----
`timescale 1ns / 100ps

module tb_depth_pixel_to_point;

  localparam int CLK_PERIOD  = 2;
  localparam int LONG_HOLD   = 80;   // cycles the receiver holds off during the backpressure run
  localparam int PHASES      = 11;   // calibration settings walked after the directed rows
  localparam int PHASE_BEATS = 67;   // pixels per calibration setting
  localparam int BURST_BEATS = 40;   // back-to-back pixels offered while the receiver holds
  localparam int COORD_W     = dpp_pkg::COORD_WIDTH;
  localparam int DEPTH_W     = dpp_pkg::DEPTH_WIDTH;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  // one pixel beat as it enters the block
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] background;
    logic               frame_end;
  } pixel_t;

  // one point beat as it leaves the block
  typedef struct packed {
    logic                             point_valid;
    logic signed [dpp_pkg::OUT_W-1:0] x;
    logic signed [dpp_pkg::OUT_W-1:0] y;
    logic signed [dpp_pkg::OUT_W-1:0] z;
    logic                             frame_done;
  } point_t;

  // local copy of the calibration registers, at their stored widths
  typedef struct packed {
    logic [63:0] crop;
    logic [31:0] centre;
    logic [47:0] recip;
    logic [31:0] limits;
    logic [59:0] cam_x;
    logic [59:0] cam_y;
    logic [59:0] cam_z;
    logic [59:0] ofs;
  } calib_t;

  // directed row: pixel, whether the point is typed in, and that point
  typedef struct packed {
    pixel_t px;
    logic   typed;
    point_t want;
  } directed_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [COORD_W-1:0]               in_pixel_column;
  logic [COORD_W-1:0]               in_pixel_row;
  logic [DEPTH_W-1:0]               in_depth_sample;
  logic [DEPTH_W-1:0]               in_background_sample;
  logic                             in_frame_end;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_point_valid;
  logic signed [dpp_pkg::OUT_W-1:0] out_point_x;
  logic signed [dpp_pkg::OUT_W-1:0] out_point_y;
  logic signed [dpp_pkg::OUT_W-1:0] out_point_z;
  logic                             out_frame_done;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [dpp_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [dpp_pkg::CFG_DATA_W-1:0]   cfg_data;

  calib_t calib;               // what the registers hold right now
  point_t pending_points [$];  // predicted points, oldest first
  int     fail_count = 0;
  bit     steady = 1'b0;       // no input gaps and no new random receiver stalls while set
  bit     hold_request = 1'b0; // asks the receiver for one long hold-off

  // directed rows, all under the reset calibration (centre pixel 256,212; window 512x424;
  // margin 500 mm; identity matrix); a pixel on the principal point lands at (0, 0, depth)
  directed_row_t directed_rows [16] = '{
    // on the principal point
    '{'{12'd256, 12'd212, 16'd1000, 16'd2000, 1'b0}, 1'b1, '{1'b1, 0, 0, 256000, 1'b0}},
    // no depth reading
    '{'{12'd256, 12'd212, 16'd0, 16'd2000, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    // background nearer than the pixel
    '{'{12'd256, 12'd212, 16'd2000, 16'd1000, 1'b1}, 1'b1, '{1'b0, 0, 0, 0, 1'b1}},
    // background exactly the margin behind: not enough
    '{'{12'd256, 12'd212, 16'd1000, 16'd1500, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    // one millimetre past the margin
    '{'{12'd256, 12'd212, 16'd1000, 16'd1501, 1'b1}, 1'b1, '{1'b1, 0, 0, 256000, 1'b1}},
    // last pixel inside the window
    '{'{12'd511, 12'd423, 16'd3000, 16'd65535, 1'b0}, 1'b0, '0},
    // first column and first row past the window
    '{'{12'd512, 12'd100, 16'd1000, 16'd3000, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    '{'{12'd100, 12'd424, 16'd1000, 16'd3000, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    // window corner, smallest depth
    '{'{12'd0, 12'd0, 16'd1, 16'd65535, 1'b1}, 1'b0, '0},
    // all-ones pixel
    '{'{12'd4095, 12'd4095, 16'd65535, 16'd65535, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    // deepest pixel the default margin lets through
    '{'{12'd0, 12'd423, 16'd65034, 16'd65535, 1'b0}, 1'b0, '0},
    '{'{12'd511, 12'd0, 16'd40000, 16'd65535, 1'b1}, 1'b0, '0},
    // zero depth readings or zero background
    '{'{12'd300, 12'd212, 16'd0, 16'd0, 1'b1}, 1'b1, '{1'b0, 0, 0, 0, 1'b1}},
    '{'{12'd256, 12'd212, 16'd65535, 16'd0, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    // far corners outside the window
    '{'{12'd4095, 12'd0, 16'd1, 16'd65535, 1'b0}, 1'b1, '{1'b0, 0, 0, 0, 1'b0}},
    '{'{12'd0, 12'd4095, 16'd1, 16'd65535, 1'b1}, 1'b1, '{1'b0, 0, 0, 0, 1'b1}}
  };

  depth_pixel_to_point DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pixel_column      (in_pixel_column),
    .in_pixel_row         (in_pixel_row),
    .in_depth_sample      (in_depth_sample),
    .in_background_sample (in_background_sample),
    .in_frame_end         (in_frame_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_point_valid      (out_point_valid),
    .out_point_x          (out_point_x),
    .out_point_y          (out_point_y),
    .out_point_z          (out_point_z),
    .out_frame_done       (out_frame_done),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // point prediction
  // ---------------------------------------------------------------------------

  // drop s fraction bits, nearest, ties away from zero
  function automatic longint round_half_away(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -m : m;
  endfunction

  // signed 20-bit coefficient from slot 0 (x), 1 (y) or 2 (z) of a matrix row
  function automatic longint coef_at(logic [59:0] bits, int slot);
    logic signed [19:0] c;
    c = bits[20*slot +: 20];
    return longint'(c);
  endfunction

  // pinhole back-projection of one axis: (coord - centre) * depth / f, in Q.8 mm
  function automatic longint camera_axis(logic [COORD_W-1:0] coord, logic [15:0] centre,
                                         logic [DEPTH_W-1:0] depth, logic [23:0] recip);
    longint c, k, d, r;
    c = longint'(coord);
    k = longint'(centre);
    d = longint'(depth);
    r = longint'(recip);
    // Q.4 offset times depth times Q0.24 reciprocal is Q.28
    return round_half_away((c * 16 - k) * d * r, 20);
  endfunction

  function automatic logic signed [31:0] saturate32(longint v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    if (v < SAT_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // point expected for one pixel under the current calibration
  function automatic point_t project_pixel(pixel_t px);
    point_t             pt;
    int                 x0, x1, y0, y1, margin, floor_mm, excess, j;
    bit                 kept;
    longint             cam [3];
    longint             acc;
    logic signed [31:0] axis [3];
    x0       = int'(calib.crop[15:0]);
    x1       = int'(calib.crop[31:16]);
    y0       = int'(calib.crop[47:32]);
    y1       = int'(calib.crop[63:48]);
    margin   = int'(calib.limits[15:0]);
    floor_mm = int'(calib.limits[31:16]);
    // signed gap between background and pixel
    excess   = int'(px.background);
    excess   = excess - int'(px.depth);
    kept = px.column >= x0 && px.column < x1 && px.row >= y0 && px.row < y1 &&
           px.depth != 0 && excess > margin && px.background >= floor_mm;
    pt = '0;
    pt.frame_done = px.frame_end;
    if (!kept) return pt;
    cam[0] = camera_axis(px.column, calib.centre[15:0], px.depth, calib.recip[23:0]);
    cam[1] = camera_axis(px.row, calib.centre[31:16], px.depth, calib.recip[47:24]);
    cam[2] = longint'(px.depth);
    cam[2] = cam[2] * 256;
    // [X Y Z 1] times the 4x3 matrix, everything in Q.25 before rounding
    for (j = 0; j < 3; j++) begin
      acc = cam[0] * coef_at(calib.cam_x, j) + cam[1] * coef_at(calib.cam_y, j) +
            cam[2] * coef_at(calib.cam_z, j) + (coef_at(calib.ofs, j) <<< 25);
      axis[j] = saturate32(round_half_away(acc, 17));
    end
    pt.point_valid = 1'b1;
    pt.x = axis[0];
    pt.y = axis[1];
    pt.z = axis[2];
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // calibration settings
  // ---------------------------------------------------------------------------

  function automatic calib_t reset_calib();
    calib_t c;
    c.crop   = {16'd424, 16'd0, 16'd512, 16'd0};
    c.centre = {16'd3392, 16'd4096};
    c.recip  = {24'd45964, 24'd45964};
    c.limits = {16'd100, 16'd500};
    c.cam_x  = {20'd0, 20'd0, 20'd131072};
    c.cam_y  = {20'd0, 20'd131072, 20'd0};
    c.cam_z  = {20'd131072, 20'd0, 20'd0};
    c.ofs    = '0;
    return c;
  endfunction

  // half rotation-sized, half anywhere in the 20-bit range
  function automatic logic [19:0] random_coef();
    if ($urandom_range(0, 1)) return 20'($urandom);
    return 20'($urandom_range(0, 262144) - 131072);
  endfunction

  function automatic calib_t phase_calib(int phase);
    calib_t      c;
    logic [15:0] x0, y0;
    c = reset_calib();
    case (phase)
      0: c = '0;   // everything cleared: empty window
      1: c = '1;   // everything set: empty window again
      2, 3: begin
        // full window, steepest focal, widest coefficients: drives saturation both ways
        c.crop   = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        c.recip  = '1;
        c.limits = '0;
        c.centre = (phase == 2) ? '1 : '0;
        c.cam_x  = (phase == 2) ? {3{20'h7FFFF}} : {3{20'h80000}};
        c.cam_y  = (phase == 2) ? {3{20'h7FFFF}} : {3{20'h80000}};
        c.cam_z  = (phase == 2) ? {3{20'h7FFFF}} : {3{20'h80000}};
        c.ofs    = (phase == 2) ? {3{20'h7FFFF}} : {3{20'h80000}};
      end
      4: begin
        // zero reciprocal focal, no margin, minimum background binding
        c.recip  = '0;
        c.limits = {16'd3000, 16'd0};
      end
      5: c.crop = {16'd50, 16'd50, 16'd100, 16'd600};  // inverted columns, empty rows
      default: begin
        x0 = 16'($urandom_range(0, 300));
        y0 = 16'($urandom_range(0, 300));
        c.crop = {16'(y0 + $urandom_range(1, 4000)), y0, 16'(x0 + $urandom_range(1, 4000)), x0};
        if ($urandom_range(0, 7) == 0) c.crop = {$urandom, $urandom};
        c.centre = $urandom_range(0, 1) ? $urandom :
                   {16'(y0 * 16 + $urandom_range(0, 32000)), 16'(x0 * 16 + $urandom_range(0, 32000))};
        c.recip = $urandom_range(0, 1) ? 48'({$urandom, $urandom}) :
                  {24'($urandom_range(15000, 120000)), 24'($urandom_range(15000, 120000))};
        c.limits = ($urandom_range(0, 3) == 0) ? $urandom :
                   {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 2000))};
        c.cam_x = {random_coef(), random_coef(), random_coef()};
        c.cam_y = {random_coef(), random_coef(), random_coef()};
        c.cam_z = {random_coef(), random_coef(), random_coef()};
        c.ofs   = {20'($urandom), 20'($urandom), 20'($urandom)};
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly pixels that pass every test, some on a test's edge, some noise
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned x0, x1, y0, y1, margin, floor_mm, lo, pick;
    x0       = 32'(calib.crop[15:0]);
    x1       = 32'(calib.crop[31:16]);
    y0       = 32'(calib.crop[47:32]);
    y1       = 32'(calib.crop[63:48]);
    margin   = 32'(calib.limits[15:0]);
    floor_mm = 32'(calib.limits[31:16]);
    pick     = $urandom_range(0, 99);
    px.column     = COORD_W'($urandom);
    px.row        = COORD_W'($urandom);
    px.depth      = DEPTH_W'($urandom);
    px.background = DEPTH_W'($urandom);
    px.frame_end  = ($urandom_range(0, 15) == 0);
    if (pick >= 85) return px;
    if (x0 < x1 && x0 < 4096)
      px.column = COORD_W'($urandom_range(x0, (x1 > 4096) ? 4095 : x1 - 1));
    if (y0 < y1 && y0 < 4096)
      px.row = COORD_W'($urandom_range(y0, (y1 > 4096) ? 4095 : y1 - 1));
    if (margin < 65534) begin
      // typical room depths half the time
      px.depth = DEPTH_W'($urandom_range(0, 1) ? $urandom_range(1, 65534 - margin) :
                 $urandom_range(1, (65534 - margin < 8000) ? 65534 - margin : 8000));
      lo = 32'(px.depth) + margin + 1;
      if (lo < floor_mm) lo = floor_mm;
      if (lo <= 65535) px.background = DEPTH_W'($urandom_range(lo, 65535));
    end
    if (pick >= 70) begin
      case ($urandom_range(0, 5))
        0:       px.column = COORD_W'(x0 - 1);
        1:       px.column = COORD_W'(x1);
        2:       px.row = COORD_W'(y0 - 1);
        3:       px.row = COORD_W'(y1);
        4:       px.background = DEPTH_W'(32'(px.depth) + margin);
        default: px.background = DEPTH_W'(floor_mm - 1);
      endcase
    end
    return px;
  endfunction

  // offer one pixel, hold it until taken, then log its point
  task automatic send_pixel(input pixel_t px, input logic typed, input point_t want);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_pixel_column      <= px.column;
    in_pixel_row         <= px.row;
    in_depth_sample      <= px.depth;
    in_background_sample <= px.background;
    in_frame_end         <= px.frame_end;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(typed ? want : project_pixel(px));
  endtask

  // stop offering and let every pending point come out
  task automatic pause_input();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // cfg_valid stays up across back-to-back writes; the caller lowers it
  task automatic write_register(input logic [dpp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dpp_pkg::REG_CROP_WINDOW: calib.crop   = value;
      dpp_pkg::REG_PRINCIPAL:   calib.centre = value[31:0];
      dpp_pkg::REG_RECIP_FOCAL: calib.recip  = value[47:0];
      dpp_pkg::REG_BG_LIMITS:   calib.limits = value[31:0];
      dpp_pkg::REG_ROW_CAM_X:   calib.cam_x  = value[59:0];
      dpp_pkg::REG_ROW_CAM_Y:   calib.cam_y  = value[59:0];
      dpp_pkg::REG_ROW_CAM_Z:   calib.cam_z  = value[59:0];
      dpp_pkg::REG_ROW_OFFSET:  calib.ofs    = value[59:0];
      default: ;
    endcase
  endtask

  // write all eight registers; pad fills the bits above each register's width
  task automatic program_calib(input calib_t c, input logic [63:0] pad);
    write_register(dpp_pkg::REG_CROP_WINDOW, c.crop);
    write_register(dpp_pkg::REG_PRINCIPAL, {pad[63:32], c.centre});
    write_register(dpp_pkg::REG_RECIP_FOCAL, {pad[63:48], c.recip});
    write_register(dpp_pkg::REG_BG_LIMITS, {pad[63:32], c.limits});
    write_register(dpp_pkg::REG_ROW_CAM_X, {pad[63:60], c.cam_x});
    write_register(dpp_pkg::REG_ROW_CAM_Y, {pad[63:60], c.cam_y});
    write_register(dpp_pkg::REG_ROW_CAM_Z, {pad[63:60], c.cam_z});
    write_register(dpp_pkg::REG_ROW_OFFSET, {pad[63:60], c.ofs});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int n, phase;
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_pixel_column      <= '0;
    in_pixel_row         <= '0;
    in_depth_sample      <= '0;
    in_background_sample <= '0;
    in_frame_end         <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    calib = reset_calib();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows against the reset calibration
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);

    // each setting is loaded with the pipeline empty, then gets a random pixel stream
    for (phase = 0; phase < PHASES; phase++) begin
      pause_input();
      program_calib(phase_calib(phase),
                    (phase == 1) ? '1 : ((phase >= 6) ? {$urandom, $urandom} : '0));
      steady = (phase == 7);
      // receiver holds off while pixels keep coming: pipeline fills and stalls input
      if (phase == 6) hold_request = 1'b1;
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 6) steady = (n < BURST_BEATS);
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    // drain, then watch a while longer for stray beats
    pause_input();
    repeat (dpp_pkg::NUM_STAGES * 4) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // receiver: random stall runs, a long hold on request, none while steady
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // point checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // every accepted point beat is matched with the oldest prediction
  always @(posedge clk) begin : point_check
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("point beat with nothing pending");
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("point_valid", 32'(want.point_valid), 32'(out_point_valid));
        check_field("point_x", want.x, out_point_x);
        check_field("point_y", want.y, out_point_y);
        check_field("point_z", want.z, out_point_z);
        check_field("frame_done", 32'(want.frame_done), 32'(out_frame_done));
      end
    end
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
